>>> rtl/crc_pkg.sv
// crc_pkg: shared types and constants for the color range centroid block
// holds register indexes, reset values, state encoding and the
// controller/datapath command and status structs; no dependencies
package crc_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_HIGH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_LOW     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_HIGH    = 3'd6;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] RST_WINDOW_WIDTH = 8'd75;
  localparam logic [CFG_DATA_W-1:0] RST_RED_LOW      = 8'd200;
  localparam logic [CFG_DATA_W-1:0] RST_RED_HIGH     = 8'd255;
  localparam logic [CFG_DATA_W-1:0] RST_GREEN_LOW    = 8'd0;
  localparam logic [CFG_DATA_W-1:0] RST_GREEN_HIGH   = 8'd100;
  localparam logic [CFG_DATA_W-1:0] RST_BLUE_LOW     = 8'd200;
  localparam logic [CFG_DATA_W-1:0] RST_BLUE_HIGH    = 8'd255;

  // pixel channel width
  localparam int CHAN_W = 8;

  // match counter saturates here, so the sums never overflow
  localparam int MATCH_W   = 15;
  localparam int MATCH_CAP = 16384;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] window_width;
    logic [CFG_DATA_W-1:0] red_low;
    logic [CFG_DATA_W-1:0] red_high;
    logic [CFG_DATA_W-1:0] green_low;
    logic [CFG_DATA_W-1:0] green_high;
    logic [CFG_DATA_W-1:0] blue_low;
    logic [CFG_DATA_W-1:0] blue_high;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accum;
    logic load;
    logic step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_step;
  } stat_t;

endpackage

>>> rtl/crc_ctrl.sv
// crc_ctrl: sequencer for pixel accumulation, centroid division and result beat
// depends on crc_pkg for state_t, cmd_t and stat_t
module crc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          last_pixel,
  input  crc_pkg::stat_t stat,
  output crc_pkg::cmd_t  cmd,
  output logic          busy,
  output logic          done
);
  import crc_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RUN: begin
        if (start && last_pixel) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (stat.last_step) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        state_next = ST_RUN;
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd.accum = (state == ST_RUN) && start;
    cmd.load  = (state == ST_LOAD);
    cmd.step  = (state == ST_DIV);
    busy      = (state != ST_RUN);
    done      = (state == ST_OUT);
  end

endmodule

>>> rtl/crc_datapath.sv
// crc_datapath: color bounds test, coordinate counters, sums and two
// restoring dividers that produce the centroid one quotient bit per cycle
// depends on crc_pkg for cfg_t, cmd_t, stat_t and match constants
module crc_datapath #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  crc_pkg::cfg_t                 cfg,
  input  crc_pkg::cmd_t                 cmd,
  input  logic [crc_pkg::CHAN_W-1:0]    red,
  input  logic [crc_pkg::CHAN_W-1:0]    green,
  input  logic [crc_pkg::CHAN_W-1:0]    blue,
  output crc_pkg::stat_t                stat,
  output logic [COL_W-1:0]              centroid_x,
  output logic [ROW_W-1:0]              centroid_y,
  output logic [crc_pkg::MATCH_W-1:0]   match_count,
  output logic                          found
);
  import crc_pkg::*;

  localparam int Q_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int SUM_W  = Q_W + MATCH_W - 1;
  localparam int STEP_W = $clog2(Q_W + 1);
  localparam int EW_W   = (COL_W + 1 > CFG_DATA_W + 1) ? COL_W + 1 : CFG_DATA_W + 1;

  // window accumulation state
  logic [COL_W-1:0]   column;
  logic [ROW_W-1:0]   row;
  logic [SUM_W-1:0]   sum_columns;
  logic [SUM_W-1:0]   sum_rows;
  logic [MATCH_W-1:0] hit_count;

  // divider state
  logic [SUM_W-1:0]   rem_x;
  logic [SUM_W-1:0]   rem_y;
  logic [SUM_W-1:0]   divisor;
  logic [Q_W-1:0]     quot_x;
  logic [Q_W-1:0]     quot_y;
  logic [STEP_W-1:0]  step_cnt;

  logic [EW_W-1:0]    ww_ext;
  logic [EW_W-1:0]    w_eff;
  logic               pix_match;
  logic               row_wrap;
  logic               ge_x;
  logic               ge_y;

  // clamp the configured width into 1..MAX_WIDTH
  always_comb begin
    ww_ext = EW_W'(cfg.window_width);
    if (cfg.window_width == '0) begin
      w_eff = EW_W'(1);
    end else if (ww_ext > EW_W'(MAX_WIDTH)) begin
      w_eff = EW_W'(MAX_WIDTH);
    end else begin
      w_eff = ww_ext;
    end
  end

  // inclusive bounds on every channel, ignored once the count is capped
  assign pix_match = (red   >= cfg.red_low)   && (red   <= cfg.red_high)   &&
                     (green >= cfg.green_low) && (green <= cfg.green_high) &&
                     (blue  >= cfg.blue_low)  && (blue  <= cfg.blue_high)  &&
                     (hit_count < MATCH_W'(MATCH_CAP));

  assign row_wrap = (EW_W'(column) + EW_W'(1)) >= w_eff;

  // window counters and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      row         <= '0;
      sum_columns <= '0;
      sum_rows    <= '0;
      hit_count   <= '0;
    end else if (cmd.load) begin
      column      <= '0;
      row         <= '0;
      sum_columns <= '0;
      sum_rows    <= '0;
      hit_count   <= '0;
    end else if (cmd.accum) begin
      if (pix_match) begin
        sum_columns <= sum_columns + SUM_W'(column);
        sum_rows    <= sum_rows + SUM_W'(row);
        hit_count   <= hit_count + MATCH_W'(1);
      end
      if (row_wrap) begin
        column <= '0;
        if (row < ROW_W'(MAX_HEIGHT - 1)) begin
          row <= row + ROW_W'(1);
        end
      end else begin
        column <= column + COL_W'(1);
      end
    end
  end

  // one compare and subtract per quotient bit
  assign ge_x = rem_x >= divisor;
  assign ge_y = rem_y >= divisor;

  // restoring dividers, quotient fits in Q_W bits since sum < count << Q_W
  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.load) begin
      step_cnt <= STEP_W'(Q_W - 1);
    end else if (cmd.step) begin
      step_cnt <= step_cnt - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_x       <= sum_columns;
      rem_y       <= sum_rows;
      divisor     <= SUM_W'(hit_count) << (Q_W - 1);
      quot_x      <= '0;
      quot_y      <= '0;
      match_count <= hit_count;
      found       <= (hit_count != '0);
    end else if (cmd.step) begin
      if (ge_x) begin
        rem_x <= rem_x - divisor;
      end
      if (ge_y) begin
        rem_y <= rem_y - divisor;
      end
      quot_x  <= {quot_x[Q_W-2:0], ge_x};
      quot_y  <= {quot_y[Q_W-2:0], ge_y};
      divisor <= divisor >> 1;
    end
  end

  assign stat.last_step = (step_cnt == '0);

  // no match gives a zero centroid
  assign centroid_x = found ? quot_x[COL_W-1:0] : '0;
  assign centroid_y = found ? quot_y[ROW_W-1:0] : '0;

endmodule

>>> rtl/color_range_centroid.sv
// color_range_centroid: top level with configuration registers, crc_ctrl and
// crc_datapath; depends on crc_pkg. Pixels are taken one per cycle while busy is low.
// After the last pixel busy stays high through one load, one step per quotient bit
// of the restoring dividers, Q_W = max(clog2(MAX_WIDTH), clog2(MAX_HEIGHT)) (7 at
// defaults), and one result beat on done. The receiver cannot stall.
// Synchronous reset restores register defaults and clears the window counters.
module color_range_centroid #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [crc_pkg::CHAN_W-1:0]      red,
  input  logic [crc_pkg::CHAN_W-1:0]      green,
  input  logic [crc_pkg::CHAN_W-1:0]      blue,
  input  logic                            last_pixel,
  output logic                            done,
  output logic [COL_W-1:0]                centroid_x,
  output logic [ROW_W-1:0]                centroid_y,
  output logic [crc_pkg::MATCH_W-1:0]     match_count,
  output logic                            found,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import crc_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_width <= RST_WINDOW_WIDTH;
      cfg.red_low      <= RST_RED_LOW;
      cfg.red_high     <= RST_RED_HIGH;
      cfg.green_low    <= RST_GREEN_LOW;
      cfg.green_high   <= RST_GREEN_HIGH;
      cfg.blue_low     <= RST_BLUE_LOW;
      cfg.blue_high    <= RST_BLUE_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_WIDTH: cfg.window_width <= cfg_data;
        REG_RED_LOW:      cfg.red_low      <= cfg_data;
        REG_RED_HIGH:     cfg.red_high     <= cfg_data;
        REG_GREEN_LOW:    cfg.green_low    <= cfg_data;
        REG_GREEN_HIGH:   cfg.green_high   <= cfg_data;
        REG_BLUE_LOW:     cfg.blue_low     <= cfg_data;
        REG_BLUE_HIGH:    cfg.blue_high    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  crc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_pixel (last_pixel),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy),
    .done       (done)
  );

  crc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .stat        (stat),
    .centroid_x  (centroid_x),
    .centroid_y  (centroid_y),
    .match_count (match_count),
    .found       (found)
  );

  // a result beat only comes while busy, and frees the block next cycle
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy ##1 !busy)
    else $error("result beat outside busy window or busy held after it");

  // the last pixel of a window starts the division
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_pixel) |=> busy)
    else $error("last pixel accepted without entering division");

  // found agrees with the reported count
  a_found_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (found == (match_count != '0)))
    else $error("found flag disagrees with match count");

  // an empty window reports a zero centroid
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (centroid_x == '0) && (centroid_y == '0))
    else $error("nonzero centroid with no match");

endmodule
